[rtl/rltmr_pkg.sv]
// Shared types and constants of the reload timer with cycle prescaler.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Has no dependencies.
package rltmr_pkg;

  // Width of the tick counter; any value from 8 to 32 works.
  localparam int unsigned CounterWidth = 32;

  localparam int unsigned CyclesWidth  = 8;
  localparam int unsigned IrqWidth     = 8;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned FracWidth    = 3;
  localparam int unsigned TicksWidth   = 8;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;

  // Leftover cycle masks for the two divider modes.
  localparam logic [FracWidth-1:0] FracMaskDiv2 = 3'h1;
  localparam logic [FracWidth-1:0] FracMaskDiv4 = 3'h3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgDividerOff   = 2'd0,
    CfgReloadOnZero = 2'd1,
    CfgIrqEnable    = 2'd2,
    CfgReloadValue  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic ticks_zero;
  } dp_sts_t;

endpackage

[rtl/rltmr_if.sv]
// Valid/ready channel interfaces of the reload timer: instruction cycles in,
// interrupt count and counter value out. Depends on rltmr_pkg.
interface rltmr_in_if;
  logic                                valid;
  logic                                ready;
  logic [rltmr_pkg::CyclesWidth-1:0]   cpu_cycles;

  modport source (output valid, output cpu_cycles, input ready);
  modport sink   (input valid, input cpu_cycles, output ready);
endinterface

interface rltmr_out_if;
  logic                                valid;
  logic                                ready;
  logic [rltmr_pkg::IrqWidth-1:0]      irq_count;
  logic [rltmr_pkg::ValueWidth-1:0]    counter_value;

  modport source (output valid, output irq_count, output counter_value, input ready);
  modport sink   (input valid, input irq_count, input counter_value, output ready);
endinterface

[rtl/rltmr_ctrl.sv]
// Controller of the reload timer: sequences load, tick steps and result transfer.
// Drives the datapath through rltmr_pkg::dp_cmd_t. Depends on rltmr_pkg.
module rltmr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rltmr_pkg::dp_sts_t  sts_i,
  output rltmr_pkg::dp_cmd_t  cmd_o
);

  rltmr_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rltmr_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      rltmr_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rltmr_pkg::StRun;
        end
      end
      rltmr_pkg::StRun: begin
        if (!sts_i.ticks_zero) begin
          cmd_o.step = 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          // The output register is free or is emptied by a transfer this cycle.
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = rltmr_pkg::StIdle;
        end
      end
      default: state_d = rltmr_pkg::StIdle;
    endcase
  end

  assign in_ready_o  = (state_q == rltmr_pkg::StIdle);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == rltmr_pkg::StRun))
    else $error("accepted item did not start a run");

  a_emit_after_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.ticks_zero)
    else $error("result emitted with ticks outstanding");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_step_needs_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !sts_i.ticks_zero)
    else $error("tick step with no ticks left");
`endif

endmodule

[rtl/rltmr_dp.sv]
// Datapath of the reload timer: configuration registers, prescaler fraction,
// tick counter, per-item tick and interrupt counts, result register.
// Depends on rltmr_pkg.
module rltmr_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rltmr_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [rltmr_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic [rltmr_pkg::CyclesWidth-1:0]     cpu_cycles_i,
  input  rltmr_pkg::dp_cmd_t                    cmd_i,
  output rltmr_pkg::dp_sts_t                    sts_o,
  output logic [rltmr_pkg::IrqWidth-1:0]        irq_count_o,
  output logic [rltmr_pkg::ValueWidth-1:0]      counter_value_o
);

  logic                                  divider_off_q;
  logic                                  reload_on_zero_q;
  logic                                  irq_enable_q;
  logic [rltmr_pkg::ValueWidth-1:0]      reload_value_q;

  logic [rltmr_pkg::CounterWidth-1:0]    cnt_q, cnt_d;
  logic [rltmr_pkg::FracWidth-1:0]       frac_q, frac_d;
  logic [rltmr_pkg::TicksWidth-1:0]      ticks_q, ticks_d;
  logic [rltmr_pkg::IrqWidth-1:0]        irq_q, irq_d;
  logic [rltmr_pkg::IrqWidth-1:0]        irq_count_q;
  logic [rltmr_pkg::ValueWidth-1:0]      counter_value_q;

  logic [rltmr_pkg::FracWidth-1:0]       frac_mask;
  logic [rltmr_pkg::FracWidth-1:0]       frac_sum;
  logic [rltmr_pkg::FracWidth-1:0]       frac_limit;
  logic [rltmr_pkg::TicksWidth-1:0]      base_ticks;
  logic [rltmr_pkg::CounterWidth-1:0]    cnt_dec;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divider_off_q    <= 1'b0;
      reload_on_zero_q <= 1'b0;
      irq_enable_q     <= 1'b0;
      reload_value_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (rltmr_pkg::cfg_idx_e'(cfg_idx_i))
        rltmr_pkg::CfgDividerOff:   divider_off_q    <= cfg_data_i[0];
        rltmr_pkg::CfgReloadOnZero: reload_on_zero_q <= cfg_data_i[0];
        rltmr_pkg::CfgIrqEnable:    irq_enable_q     <= cfg_data_i[0];
        rltmr_pkg::CfgReloadValue:  reload_value_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Prescaler: whole ticks from the shift, plus one when the carried fraction
  // reaches a full tick. Only one tick is taken from the fraction per item.
  always_comb begin
    frac_mask  = divider_off_q ? rltmr_pkg::FracMaskDiv4 : rltmr_pkg::FracMaskDiv2;
    frac_limit = divider_off_q ? 3'd4 : 3'd2;
    frac_sum   = frac_q + (cpu_cycles_i[rltmr_pkg::FracWidth-1:0] & frac_mask);
    base_ticks = divider_off_q ? (cpu_cycles_i >> 2) : (cpu_cycles_i >> 1);
  end

  assign cnt_dec = cnt_q - 1'b1;

  always_comb begin
    cnt_d   = cnt_q;
    frac_d  = frac_q;
    ticks_d = ticks_q;
    irq_d   = irq_q;
    if (cmd_i.load) begin
      irq_d = '0;
      if (frac_sum >= frac_limit) begin
        frac_d  = frac_sum - frac_limit;
        ticks_d = base_ticks + 1'b1;
      end else begin
        frac_d  = frac_sum;
        ticks_d = base_ticks;
      end
    end else if (cmd_i.step) begin
      ticks_d = ticks_q - 1'b1;
      cnt_d   = cnt_dec;
      if (cnt_dec == '0) begin
        if (reload_on_zero_q) begin
          cnt_d = reload_value_q[rltmr_pkg::CounterWidth-1:0];
        end
        if (irq_enable_q) begin
          irq_d = irq_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      frac_q  <= '0;
      ticks_q <= '0;
      irq_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      frac_q  <= frac_d;
      ticks_q <= ticks_d;
      irq_q   <= irq_d;
    end
  end

  // Result register; holds its contents until the next item is finished.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      irq_count_q     <= irq_q;
      counter_value_q <= rltmr_pkg::ValueWidth'(cnt_q);
    end
  end

  assign sts_o.ticks_zero = (ticks_q == '0);
  assign irq_count_o      = irq_count_q;
  assign counter_value_o  = counter_value_q;

`ifndef NO_ASSERTIONS
  a_frac_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_q <= 3'd6)
    else $error("cycle fraction out of range");

  a_irq_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (irq_q <= ticks_q + irq_q) && (irq_q <= 8'd128))
    else $error("interrupt count out of range");

  a_step_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (ticks_q == $past(ticks_q) - 1'b1))
    else $error("tick count did not decrement");
`endif

endmodule

[rtl/reload_timer_with_cycle_prescaler.sv]
// Top level of the reload timer with cycle prescaler.
// Joins rltmr_ctrl and rltmr_dp; channels use rltmr_in_if and rltmr_out_if.
// Depends on rltmr_pkg, rltmr_if, rltmr_ctrl and rltmr_dp.
//
//   Port    Dir  Payload                          Meaning
//   in_i    in   cpu_cycles[7:0]                  cycles of one instruction
//   out_o   out  irq_count[7:0], counter_value    interrupts and counter after it
//   cfg_*   in   cfg_idx_i[1:0], cfg_data_i[31:0] register write, no read-back
//
// An item is loaded, then the counter is decremented once per tick, and then
// the result is moved into the output register, once that register is free.
// Ticks are up to 128 per item.
// A new item is taken while a result still waits in the output register.
// Reset clears the configuration registers, the counter and the cycle fraction.
module reload_timer_with_cycle_prescaler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  rltmr_in_if.sink                            in_i,
  rltmr_out_if.source                         out_o,
  input  logic                                cfg_we_i,
  input  logic [rltmr_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [rltmr_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  rltmr_pkg::dp_cmd_t cmd;
  rltmr_pkg::dp_sts_t sts;

  rltmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rltmr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cpu_cycles_i    (in_i.cpu_cycles),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .irq_count_o     (out_o.irq_count),
    .counter_value_o (out_o.counter_value)
  );

endmodule
